// ===== src/tletok_pkg.sv =====
package tletok_pkg;

  // Default line buffer depth; the valid range is 2 to 62
  localparam int LINE_CAPACITY_DEF = 32;

  // Length and index field of a queued command, wide enough for the largest line
  localparam int LEN_W = 6;

  // Token count field width
  localparam int TCNT_W = 5;

  // Depth of the command queue between the front and the back end
  localparam int Q_DEPTH = 2;

  // Output packing widths
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  // Result channel codes
  localparam logic [1:0] CH_ECHO  = 2'd0;
  localparam logic [1:0] CH_TOKEN = 2'd1;
  localparam logic [1:0] CH_EOL   = 2'd2;

  // Terminal byte codes
  localparam logic [7:0] BS_CHAR    = 8'h08;
  localparam logic [7:0] DEL_CHAR   = 8'h7F;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] LF_CHAR    = 8'h0A;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] TILDE_CHAR = 8'h7E;

  // Work handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_LINE   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;   // character to store and echo
    logic             echo;   // echo was on when the byte arrived
    logic [LEN_W-1:0] len;    // store index for append, line length for line end
  } cmd_t;

endpackage

// ===== src/terminal_line_editor_tokenizer_unit.sv =====
// Terminal line editor with echo and tokenizer.
// Input stream: one received terminal byte per transaction on in_tdata.
// Output stream: echo bytes (tuser 0), token characters (tuser 1, token end
// in tdata bit 8) and an end-of-line item (tuser 2, token count in tdata
// bits 13:9); tlast marks the final result caused by one input byte.
// cfg_wr_en/cfg_wr_data write the echo enable; write it only while idle.
// The front end takes a byte every cycle while its two-entry command queue
// has room; a byte's first result passes through the queue and the output register.
// An appended character is stored and echoed; an erase echoes backspace,
// space, backspace. A line end echoes CR and LF, then walks each stored
// character through the line buffer's registered read port (an address and
// a data state), then emits a flush and an end-of-line item.
// When the receiver stalls, the output register holds its transaction, the
// back end waits and the queue fills, after which in_tready drops.
// Reset empties the line and the queue and turns echo on; no clearing
// pass is needed since only written buffer entries are ever read.
module terminal_line_editor_tokenizer_unit
  import tletok_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // [0] echo_enable
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [7:0] out_byte, [8] token_end, [13:9] token_count
  output logic [1:0]  out_tuser,     // [1:0] channel
  output logic        out_tlast      // last
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_wdata;
  cmd_t q_rdata;

  tletok_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  tletok_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .full     (q_full),
    .empty    (q_empty)
  );

  tletok_back #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// ===== src/tletok_fifo.sv =====
module tletok_fifo
  import tletok_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             entry_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/tletok_front.sv =====
module tletok_front
  import tletok_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_data
);

  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

  logic             echo_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic             accept;
  logic [7:0]       rx_byte;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign rx_byte   = in_tdata;

  // Classify the byte, track the fill level and queue work for the back end
  always_comb begin
    fill_nxt    = fill_r;
    q_push      = 1'b0;
    q_data.kind = CMD_APPEND;
    q_data.data = rx_byte;
    q_data.echo = echo_r;
    q_data.len  = LEN_W'(fill_r);
    if (accept) begin
      if (rx_byte == BS_CHAR || rx_byte == DEL_CHAR) begin
        if (fill_r != '0) begin
          fill_nxt    = fill_r - 1'b1;
          q_push      = echo_r;
          q_data.kind = CMD_ERASE;
        end
      end else if (rx_byte == CR_CHAR || rx_byte == LF_CHAR) begin
        fill_nxt    = '0;
        q_push      = 1'b1;
        q_data.kind = CMD_LINE;
      end else if (rx_byte >= SPACE_CHAR && rx_byte <= TILDE_CHAR) begin
        if (fill_r < CNT_W'(LINE_CAPACITY)) begin
          fill_nxt    = fill_r + 1'b1;
          q_push      = 1'b1;
          q_data.kind = CMD_APPEND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r <= 1'b1;
      fill_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        echo_r <= cfg_wr_data;
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== src/tletok_back.sv =====
module tletok_back
  import tletok_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_data,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
  localparam int IDX_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ERASE = 7'b0000010,
    S_CRLF  = 7'b0000100,
    S_WADDR = 7'b0001000,
    S_WDATA = 7'b0010000,
    S_FLUSH = 7'b0100000,
    S_EOL   = 7'b1000000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [1:0]        seq_r;
  logic [1:0]        seq_nxt;
  logic [CNT_W-1:0]  len_r;
  logic [CNT_W-1:0]  len_nxt;
  logic [CNT_W-1:0]  rd_idx_r;
  logic [CNT_W-1:0]  rd_idx_nxt;
  logic              pend_v_r;
  logic              pend_v_nxt;
  logic [7:0]        pend_c_r;
  logic [7:0]        pend_c_nxt;
  logic [TCNT_W-1:0] count_r;
  logic [TCNT_W-1:0] count_nxt;
  logic [7:0]        rd_data_r;
  logic [7:0]        line_mem [LINE_CAPACITY];

  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;

  logic              slot_free;
  logic              emit;
  logic [1:0]        e_chan;
  logic [7:0]        e_byte;
  logic              e_tend;
  logic [TCNT_W-1:0] e_cnt;
  logic              e_last;

  logic              out_valid_r;
  logic [1:0]        out_chan_r;
  logic [7:0]        out_byte_r;
  logic              out_tend_r;
  logic [TCNT_W-1:0] out_cnt_r;
  logic              out_last_r;

  assign slot_free = !out_valid_r || out_tready;
  assign q_pop     = (state_r == S_IDLE) && !q_empty && slot_free;
  assign mem_wa    = q_data.len[IDX_W-1:0];

  // Sequence echo output, buffer writes and the token walk
  always_comb begin
    state_nxt  = state_r;
    seq_nxt    = seq_r;
    len_nxt    = len_r;
    rd_idx_nxt = rd_idx_r;
    pend_v_nxt = pend_v_r;
    pend_c_nxt = pend_c_r;
    count_nxt  = count_r;
    mem_we     = 1'b0;
    emit       = 1'b0;
    e_chan     = CH_ECHO;
    e_byte     = 8'h00;
    e_tend     = 1'b0;
    e_cnt      = '0;
    e_last     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          unique case (q_data.kind)
            CMD_APPEND: begin
              mem_we = 1'b1;
              emit   = q_data.echo;
              e_byte = q_data.data;
              e_last = 1'b1;
            end
            CMD_ERASE: begin
              emit      = 1'b1;
              e_byte    = BS_CHAR;
              seq_nxt   = 2'd1;
              state_nxt = S_ERASE;
            end
            CMD_LINE: begin
              len_nxt    = q_data.len[CNT_W-1:0];
              rd_idx_nxt = '0;
              pend_v_nxt = 1'b0;
              count_nxt  = '0;
              if (q_data.echo) begin
                emit      = 1'b1;
                e_byte    = CR_CHAR;
                state_nxt = S_CRLF;
              end else if (q_data.len == '0) begin
                state_nxt = S_EOL;
              end else begin
                state_nxt = S_WADDR;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ERASE: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_byte  = (seq_r == 2'd1) ? SPACE_CHAR : BS_CHAR;
          e_last  = (seq_r == 2'd2);
          seq_nxt = seq_r + 2'd1;
          if (seq_r == 2'd2) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CRLF: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_byte    = LF_CHAR;
          state_nxt = (len_r == '0) ? S_EOL : S_WADDR;
        end
      end
      S_WADDR: begin
        state_nxt = S_WDATA;
      end
      S_WDATA: begin
        if (slot_free) begin
          e_chan = CH_TOKEN;
          e_byte = pend_c_r;
          if (rd_data_r == SPACE_CHAR) begin
            emit       = pend_v_r;
            e_tend     = 1'b1;
            pend_v_nxt = 1'b0;
            if (pend_v_r) begin
              count_nxt = count_r + 1'b1;
            end
          end else begin
            emit       = pend_v_r;
            pend_c_nxt = rd_data_r;
            pend_v_nxt = 1'b1;
          end
          rd_idx_nxt = rd_idx_r + 1'b1;
          state_nxt  = ((rd_idx_r + 1'b1) < len_r) ? S_WADDR : S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          emit       = pend_v_r;
          e_chan     = CH_TOKEN;
          e_byte     = pend_c_r;
          e_tend     = 1'b1;
          pend_v_nxt = 1'b0;
          if (pend_v_r) begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_EOL;
        end
      end
      S_EOL: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_chan    = CH_EOL;
          e_cnt     = count_r;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      seq_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seq_r    <= seq_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    rd_idx_r <= rd_idx_nxt;
    pend_c_r <= pend_c_nxt;
    count_r  <= count_nxt;
  end

  // Line buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_wa] <= q_data.data;
    end
    rd_data_r <= line_mem[rd_idx_r[IDX_W-1:0]];
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_chan_r <= e_chan;
      out_byte_r <= e_byte;
      out_tend_r <= e_tend;
      out_cnt_r  <= e_cnt;
      out_last_r <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_chan_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_tend_r, out_byte_r};

endmodule

// ===== src/tletok_checker.sv =====
module tletok_checker
  import tletok_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // End-of-line item always closes the results of its byte
  a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == CH_EOL) |-> (out_tlast && out_tdata[7:0] == 8'h00))
    else $error("end-of-line item without tlast or with nonzero byte");

  // Token characters never carry a space or a count and never end the byte
  a_token_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == CH_TOKEN) |->
      (out_tdata[7:0] != SPACE_CHAR && out_tdata[13:9] == '0 && !out_tlast))
    else $error("token character is a space, has a count or ends the byte");

  // Echo items carry no token marks
  a_echo_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == CH_ECHO) |-> (out_tdata[13:8] == '0))
    else $error("echo item carries token fields");

  // Hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled output transaction changed");

  // No output right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind terminal_line_editor_tokenizer_unit tletok_checker u_tletok_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

// ===== bench/tb_terminal_line_editor_tokenizer_unit.sv =====
`timescale 1ns / 100ps

module tb_terminal_line_editor_tokenizer_unit;
  import tletok_pkg::*;

  // One result transaction, unpacked
  typedef struct packed {
    logic [1:0] chan;
    logic [7:0] data;
    logic       tend;
    logic [4:0] tcount;
    logic       is_last;
  } line_result_t;

  // Line editor predictor plus the queue of results still owed by the block
  class line_scoreboard;
    logic [7:0]   line_q [LINE_CAPACITY_DEF];
    int unsigned  fill;
    bit           echo_on;
    line_result_t owed_q [$];
    int unsigned  n_fail;
    int unsigned  n_checked;
    int unsigned  n_useful;
    int unsigned  n_lines;
    int unsigned  n_dropped;

    function new();
      fill    = 0;
      echo_on = 1'b1;
    endfunction

    function line_result_t make_result(logic [1:0] chan, logic [7:0] data, logic tend,
                                       logic [4:0] tcount);
      line_result_t r;
      r = '{chan: chan, data: data, tend: tend, tcount: tcount, is_last: 1'b0};
      return r;
    endfunction

    // Apply one accepted terminal byte and queue the results it causes
    function void note_byte(logic [7:0] b);
      line_result_t fresh [$];
      int unsigned  tokens;
      bit           ends;
      if (b == BS_CHAR || b == DEL_CHAR) begin
        n_useful++;
        if (fill > 0) begin
          if (echo_on) begin
            fresh = {fresh, make_result(CH_ECHO, BS_CHAR, 1'b0, 5'd0)};
            fresh = {fresh, make_result(CH_ECHO, SPACE_CHAR, 1'b0, 5'd0)};
            fresh = {fresh, make_result(CH_ECHO, BS_CHAR, 1'b0, 5'd0)};
          end
          fill--;
        end
      end else if (b == CR_CHAR || b == LF_CHAR) begin
        n_useful++;
        n_lines++;
        if (echo_on) begin
          fresh = {fresh, make_result(CH_ECHO, CR_CHAR, 1'b0, 5'd0)};
          fresh = {fresh, make_result(CH_ECHO, LF_CHAR, 1'b0, 5'd0)};
        end
        // Walk the line; a token ends before a space or at the end of the line
        tokens = 0;
        for (int i = 0; i < fill; i++) begin
          if (line_q[i] != SPACE_CHAR) begin
            ends = (i + 1 >= fill) || (line_q[i+1] == SPACE_CHAR);
            fresh = {fresh, make_result(CH_TOKEN, line_q[i], ends, 5'd0)};
            if (ends) tokens++;
          end
        end
        fresh = {fresh, make_result(CH_EOL, 8'h00, 1'b0, tokens[4:0])};
        fill = 0;
      end else if (b >= SPACE_CHAR && b <= TILDE_CHAR) begin
        n_useful++;
        if (fill < LINE_CAPACITY_DEF) begin
          line_q[fill] = b;
          fill++;
          if (echo_on) fresh = {fresh, make_result(CH_ECHO, b, 1'b0, 5'd0)};
        end else begin
          n_dropped++;
        end
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].is_last = 1'b1;
      owed_q = {owed_q, fresh};
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        n_fail++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      end
    endfunction

    // Match one result transaction against the oldest owed result
    function void check_result(line_result_t got);
      line_result_t want;
      if (owed_q.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected result: expected none, got chan %0d byte %h", $time,
                 got.chan, got.data);
        return;
      end
      want = owed_q.pop_front();
      n_checked++;
      compare_field("channel", {6'd0, want.chan}, {6'd0, got.chan});
      compare_field("out_byte", want.data, got.data);
      compare_field("token_end", {7'd0, want.tend}, {7'd0, got.tend});
      compare_field("token_count", {3'd0, want.tcount}, {3'd0, got.tcount});
      compare_field("last", {7'd0, want.is_last}, {7'd0, got.is_last});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int             send_idle_pct;
  int             stall_pct;
  int             hold_left;
  line_scoreboard sb;

  // Opening bytes: erase on empty, empty and all-space lines, field extremes,
  // spaces around tokens, ignored bytes and erase inside a line
  logic [7:0] opening_q [$] = '{BS_CHAR, DEL_CHAR, CR_CHAR, SPACE_CHAR, SPACE_CHAR, LF_CHAR,
                                SPACE_CHAR, 8'h21, TILDE_CHAR, SPACE_CHAR, SPACE_CHAR, 8'h61,
                                SPACE_CHAR, CR_CHAR, 8'h00, 8'hFF, 8'h80, 8'h1F, 8'h78,
                                DEL_CHAR, 8'h79, BS_CHAR, 8'h7A, LF_CHAR};

  terminal_line_editor_tokenizer_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive ready: a long hold-off when requested, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result('{chan: out_tuser, data: out_tdata[7:0], tend: out_tdata[8],
                        tcount: out_tdata[13:9], is_last: out_tlast});
    end
  end

  // Present one byte; entered and left at a falling edge
  task automatic send_rx_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  // Hold off the input until every owed result has come and the back end is quiet
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_echo(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.echo_on = v;
  endtask

  // Mostly well-formed lines with random words, some noise bytes
  task automatic send_random_part(input int unsigned count);
    int unsigned start;
    int          words;
    int          wlen;
    start = sb.n_useful;
    while (sb.n_useful - start < count) begin
      if ($urandom_range(0, 99) < 15) begin
        send_rx_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 2)) send_rx_byte(SPACE_CHAR);
        words = $urandom_range(0, 4);
        for (int w = 0; w < words; w++) begin
          wlen = $urandom_range(1, 6);
          for (int c = 0; c < wlen; c++) begin
            send_rx_byte(8'($urandom_range(8'h21, 8'h7E)));
            if ($urandom_range(0, 9) == 0) send_rx_byte($urandom_range(0, 1) ? BS_CHAR : DEL_CHAR);
          end
          if (w < words - 1) repeat ($urandom_range(1, 3)) send_rx_byte(SPACE_CHAR);
        end
        repeat ($urandom_range(0, 2)) send_rx_byte(SPACE_CHAR);
        send_rx_byte($urandom_range(0, 1) ? CR_CHAR : LF_CHAR);
      end
    end
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'h00;
    out_tready    = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Echo on from reset, no idling
    foreach (opening_q[i]) send_rx_byte(opening_q[i]);
    send_random_part(20);
    wait_for_results();

    // Echo off, slow sender
    write_echo(1'b0);
    send_idle_pct = 70;
    send_random_part(20);
    wait_for_results();

    // Echo on, slow receiver; one long hold-off over an overlong single-token line
    write_echo(1'b1);
    send_idle_pct = 0;
    stall_pct     = 70;
    hold_left     = 400;
    repeat (LINE_CAPACITY_DEF + 4) send_rx_byte(8'($urandom_range(8'h21, 8'h7E)));
    send_rx_byte(CR_CHAR);
    send_random_part(20);
    wait_for_results();

    // Echo off, both sides idle; a full line of one-character tokens first
    write_echo(1'b0);
    send_idle_pct = 33;
    stall_pct     = 33;
    for (int i = 0; i < LINE_CAPACITY_DEF + 2; i++) begin
      send_rx_byte((i % 2 == 0) ? 8'($urandom_range(8'h21, 8'h7E)) : SPACE_CHAR);
    end
    send_rx_byte(LF_CHAR);
    send_random_part(20);
    wait_for_results();

    $display("Covered %0d editing bytes over %0d lines with echo on and off, %0d results checked,",
             sb.n_useful, sb.n_lines, sb.n_checked);
    $display("%0d characters dropped on a full line, idle and stall mixes and a long hold-off.",
             sb.n_dropped);
    if (sb.n_fail == 0) begin
      $display("tb_terminal_line_editor_tokenizer_unit: PASS");
    end else begin
      $display("tb_terminal_line_editor_tokenizer_unit: FAIL");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #5_000_000;
    $display("tb_terminal_line_editor_tokenizer_unit: FAIL");
    $finish;
  end

endmodule
